@@ sv/ewt_pkg.sv @@
package ewt_pkg;

  localparam int unsigned EncoderTapsDef   = 20;
  localparam int unsigned ProximityTapsDef = 5;

  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned WindowW = CountW + 3;

  localparam logic [CfgW-1:0] RunLengthRst     = 16'd500;
  localparam logic [CfgW-1:0] PulseWidthRst    = 16'd5;
  localparam logic [CfgW-1:0] SlipOffsetRst    = 16'd0;
  localparam logic [CfgW-1:0] StartPositionRst = 16'd250;

  localparam int unsigned FlagRise = 0;
  localparam int unsigned FlagFall = 1;
  localparam int unsigned FlagHigh = 2;
  localparam int unsigned FlagLow  = 3;

  typedef enum logic [1:0] {
    CFG_RUN_LENGTH     = 2'd0,
    CFG_PULSE_WIDTH    = 2'd1,
    CFG_SLIP_OFFSET    = 2'd2,
    CFG_START_POSITION = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic encoder_bit;
    logic proximity_bit;
  } in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              count_valid;
    logic [CountW-1:0] position_count;
    logic              clear_pulse;
  } out_t;

  typedef struct packed {
    logic        [CfgW-1:0] run_length;
    logic        [CfgW-1:0] pulse_width;
    logic signed [CfgW-1:0] slip_offset;
    logic        [CfgW-1:0] start_position;
  } cfg_t;

  typedef struct packed {
    logic old_level;
    logic new_level;
  } lvl_t;

endpackage

@@ sv/encoder_window_trigger.sv @@
// encoder window trigger with debounced encoder and proximity inputs
// input channel: one transaction per sample tick carrying the raw encoder and
//   proximity pin bits (in_valid_i / in_stall_o / in_data_i)
// output channel: exactly one result transaction per input transaction, in
//   order (out_valid_o / out_stall_i / out_data_o)
// config channel: cfg_valid_i / cfg_ready_o with register index and data;
//   ready is always high, write only while no transaction is in flight
// result path: a transaction accepted into the input register is presented on
//   the output once the result register loads it, which a result stall delays
// throughput: one transaction per cycle while the output is not stalled; the
//   limit is the single pass from the input register through the history
//   shift, edge logic and window compare into the result register
// stall: a stalled result holds; the input register keeps loading while the
//   result register is stalled only if it is empty, then in_stall_o rises
// reset: histories, levels, count, flags and trigger clear, config registers
//   return to run length 500, width 5, slip 0, start 250
module encoder_window_trigger #(
  parameter int unsigned ENCODER_TAPS   = ewt_pkg::EncoderTapsDef,
  parameter int unsigned PROXIMITY_TAPS = ewt_pkg::ProximityTapsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ewt_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ewt_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  ewt_pkg::cfg_idx_e         cfg_index_i,
  input  logic [ewt_pkg::CfgW-1:0]  cfg_data_i
);

  ewt_pkg::cfg_t cfg_q;
  ewt_pkg::in_t  s1_q;
  logic          s1_valid_q;
  ewt_pkg::out_t out_q, res;
  logic          out_valid_q;
  logic          advance, step, s1_load;
  ewt_pkg::lvl_t enc_lvl, prox_lvl;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_length     <= ewt_pkg::RunLengthRst;
      cfg_q.pulse_width    <= ewt_pkg::PulseWidthRst;
      cfg_q.slip_offset    <= ewt_pkg::SlipOffsetRst;
      cfg_q.start_position <= ewt_pkg::StartPositionRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ewt_pkg::CFG_RUN_LENGTH:     cfg_q.run_length     <= cfg_data_i;
        ewt_pkg::CFG_PULSE_WIDTH:    cfg_q.pulse_width    <= cfg_data_i;
        ewt_pkg::CFG_SLIP_OFFSET:    cfg_q.slip_offset    <= cfg_data_i;
        ewt_pkg::CFG_START_POSITION: cfg_q.start_position <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign advance    = !(out_valid_q && out_stall_i);
  assign step       = s1_valid_q && advance;
  assign s1_load    = !s1_valid_q || advance;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  ewt_debounce #(
    .TAPS(ENCODER_TAPS)
  ) u_enc_deb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .sample_i(s1_q.encoder_bit),
    .lvl_o   (enc_lvl)
  );

  ewt_debounce #(
    .TAPS(PROXIMITY_TAPS)
  ) u_prox_deb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .sample_i(s1_q.proximity_bit),
    .lvl_o   (prox_lvl)
  );

  ewt_position u_position (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .enc_i (enc_lvl),
    .prox_i(prox_lvl),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.count_valid |-> out_q.position_count == '0)
    else $error("position count nonzero without count valid");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled while input register empty");

  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed transaction lost before result register");
`endif

endmodule

@@ sv/ewt_debounce.sv @@
module ewt_debounce #(
  parameter int unsigned TAPS = ewt_pkg::EncoderTapsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          sample_i,
  output ewt_pkg::lvl_t lvl_o
);

  logic [TAPS-1:0] hist_q, hist_d;
  logic            level_q;

  generate
    if (TAPS == 1) begin : g_single
      assign hist_d = sample_i;
    end else begin : g_shift
      assign hist_d = {hist_q[TAPS-2:0], sample_i};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      level_q <= 1'b0;
    end else if (step_i) begin
      hist_q  <= hist_d;
      level_q <= &hist_d;
    end
  end

  assign lvl_o.old_level = level_q;
  assign lvl_o.new_level = &hist_d;

endmodule

@@ sv/ewt_position.sv @@
module ewt_position (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  ewt_pkg::lvl_t  enc_i,
  input  ewt_pkg::lvl_t  prox_i,
  input  ewt_pkg::cfg_t  cfg_i,
  output ewt_pkg::out_t  res_o
);

  logic [ewt_pkg::CountW-1:0]         count_q, count_d, count_inc;
  logic [3:0]                         flags_q, flags_d, flags_set;
  logic                               trig_q, trig_d;
  logic                               edge_hit, clear_hit, in_window;
  logic signed [ewt_pkg::WindowW-1:0] lo, hi, cnt_s;

  // window bounds kept exact, no wrap
  always_comb begin
    lo = $signed({3'b000, cfg_i.start_position})
       + $signed({{3{cfg_i.slip_offset[ewt_pkg::CfgW-1]}}, cfg_i.slip_offset});
    hi = lo + $signed({3'b000, cfg_i.pulse_width});
    cnt_s = $signed({3'b000, count_inc});
    in_window = (cnt_s >= lo) && (cnt_s < hi);
  end

  always_comb begin
    flags_set = '0;
    flags_set[ewt_pkg::FlagRise] = !prox_i.old_level &&  prox_i.new_level;
    flags_set[ewt_pkg::FlagFall] =  prox_i.old_level && !prox_i.new_level;
    flags_set[ewt_pkg::FlagHigh] =  prox_i.old_level &&  prox_i.new_level;
    flags_set[ewt_pkg::FlagLow]  = !prox_i.old_level && !prox_i.new_level;

    edge_hit  = !enc_i.old_level && enc_i.new_level;
    count_inc = count_q + 1'b1;
    count_d   = edge_hit ? count_inc : count_q;
    trig_d    = edge_hit ? in_window : trig_q;
    flags_d   = flags_q | flags_set;

    clear_hit = (flags_d[ewt_pkg::FlagRise] && flags_d[ewt_pkg::FlagFall] &&
                 flags_d[ewt_pkg::FlagHigh] && !flags_d[ewt_pkg::FlagLow]) ||
                (count_d == cfg_i.run_length);

    res_o.trigger_level  = trig_d;
    res_o.count_valid    = edge_hit;
    res_o.position_count = edge_hit ? count_inc : '0;
    res_o.clear_pulse    = clear_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flags_q <= '0;
      trig_q  <= 1'b0;
    end else if (step_i) begin
      count_q <= clear_hit ? '0 : count_d;
      flags_q <= clear_hit ? '0 : flags_d;
      trig_q  <= trig_d;
    end
  end

endmodule

@@ tb/sv/ewt_tb_pkg.sv @@
package ewt_tb_pkg;

  import ewt_pkg::*;

  class trig_scoreboard;
    logic        [CfgW-1:0]             run_length;
    logic        [CfgW-1:0]             pulse_width;
    logic signed [CfgW-1:0]             slip_offset;
    logic        [CfgW-1:0]             start_position;
    logic        [EncoderTapsDef-1:0]   enc_hist;
    logic        [ProximityTapsDef-1:0] prox_hist;
    logic                               enc_level;
    logic                               prox_level;
    logic                               trig_level;
    logic        [CountW-1:0]           count;
    logic        [3:0]                  flags;
    out_t                               expected_q[$];
    int                                 errors;

    function new();
      run_length     = RunLengthRst;
      pulse_width    = PulseWidthRst;
      slip_offset    = SlipOffsetRst;
      start_position = StartPositionRst;
      enc_hist       = '0;
      prox_hist      = '0;
      enc_level      = 1'b0;
      prox_level     = 1'b0;
      trig_level     = 1'b0;
      count          = '0;
      flags          = '0;
      errors         = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_RUN_LENGTH:     run_length = value;
        CFG_PULSE_WIDTH:    pulse_width = value;
        CFG_SLIP_OFFSET:    slip_offset = value;
        CFG_START_POSITION: start_position = value;
        default: ;
      endcase
    endfunction

    // one sample tick: debounce, edge count, window compare, clear
    function void note_sample(in_t s);
      logic enc_q;
      logic prox_q;
      int   lo;
      int   hi;
      int   cnt_v;
      out_t r;
      enc_hist  = {enc_hist[EncoderTapsDef-2:0], s.encoder_bit};
      prox_hist = {prox_hist[ProximityTapsDef-2:0], s.proximity_bit};
      enc_q     = &enc_hist;
      prox_q    = &prox_hist;
      if (!prox_level && prox_q) flags[FlagRise] = 1'b1;
      if (prox_level && !prox_q) flags[FlagFall] = 1'b1;
      if (prox_level && prox_q) flags[FlagHigh] = 1'b1;
      if (!prox_level && !prox_q) flags[FlagLow] = 1'b1;
      r = '0;
      if (!enc_level && enc_q) begin
        count            = count + 1'b1;
        r.count_valid    = 1'b1;
        r.position_count = count;
        lo               = start_position;
        lo               = lo + slip_offset;
        hi               = lo + int'(pulse_width);
        cnt_v            = count;
        trig_level       = (cnt_v >= lo) && (cnt_v < hi);
      end
      enc_level  = enc_q;
      prox_level = prox_q;
      if ((flags[FlagRise] && flags[FlagFall] && flags[FlagHigh] && !flags[FlagLow]) ||
          count == run_length) begin
        count         = '0;
        flags         = '0;
        r.clear_pulse = 1'b1;
      end
      r.trigger_level = trig_level;
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s: expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t result: expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("trigger_level", want.trigger_level, got.trigger_level);
      compare("count_valid", want.count_valid, got.count_valid);
      compare("position_count", want.position_count, got.position_count);
      compare("clear_pulse", want.clear_pulse, got.clear_pulse);
    endfunction
  endclass

endpackage

@@ tb/sv/encoder_window_trigger_tb.sv @@
module encoder_window_trigger_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ewt_pkg::*;
  import ewt_tb_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int PhaseItems = 205;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  cfg_idx_e        cfg_index_i = CFG_RUN_LENGTH;
  logic [CfgW-1:0] cfg_data_i  = '0;

  trig_scoreboard sb = new();
  bit             quiet_in  = 1'b0;
  bit             quiet_out = 1'b0;
  int             stall_left = 0;
  int             cycle_cnt = 0;

  encoder_window_trigger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (stall_left == 0 && !quiet_out) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("encoder_window_trigger: mismatch");
    $finish;
  end

  task automatic send_item(input in_t s);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(s);
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic write_config(input logic [CfgW-1:0] run_v, input logic [CfgW-1:0] width_v,
                              input logic [CfgW-1:0] slip_v, input logic [CfgW-1:0] start_v);
    write_reg(CFG_RUN_LENGTH, run_v);
    write_reg(CFG_PULSE_WIDTH, width_v);
    write_reg(CFG_SLIP_OFFSET, slip_v);
    write_reg(CFG_START_POSITION, start_v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // one encoder pulse: a few lows then a run of highs, with a proximity pulse
  // that is either lined up to qualify right after the encoder edge, placed
  // at random, or the frame's encoder and proximity bits are replaced by noise
  task automatic run_frame(output int n);
    int   lo_n;
    int   hi_n;
    int   p_start;
    int   p_len;
    int   mode;
    in_t  s;
    lo_n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    mode = $urandom_range(0, 7);
    if (mode <= 2) begin
      p_len   = $urandom_range(6, 9);
      hi_n    = 16 + p_len + $urandom_range(0, 2);
      p_start = lo_n + 16;
    end else begin
      hi_n    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : $urandom_range(20, 24);
      p_start = $urandom_range(0, lo_n + hi_n - 1);
      p_len   = $urandom_range(0, 12);
    end
    n = lo_n + hi_n;
    for (int i = 0; i < n; i++) begin
      s.encoder_bit   = (i >= lo_n);
      s.proximity_bit = (i >= p_start) && (i < p_start + p_len);
      if (mode == 7) {s.encoder_bit, s.proximity_bit} = 2'($urandom_range(0, 3));
      send_item(s);
    end
  endtask

  initial begin
    int  n;
    int  sent;
    int  slip_v;
    in_t s;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all pin combinations, then a run of highs through the first encoder edge
    for (int i = 0; i < 25; i++) begin
      s.encoder_bit   = (i < 4) ? i[1] : 1'b1;
      s.proximity_bit = (i < 4) ? i[0] : 1'b1;
      send_item(s);
    end
    in_valid_i <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: write_config(16'd8, 16'd3, 16'd0, 16'd2);
        1: write_config(16'd0, 16'hFFFF, 16'h8000, 16'd0);
        2: write_config(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
        3: write_config(16'd1, 16'd0, 16'd0, 16'd1);
        4: write_config(16'd12, 16'd4, CfgW'(-3), 16'd8);
        default: begin
          slip_v = $urandom_range(0, 20);
          slip_v = slip_v - 10;
          write_config(CfgW'($urandom_range(1, 16)), CfgW'($urandom_range(0, 8)),
                       CfgW'(slip_v), CfgW'($urandom_range(0, 14)));
        end
      endcase
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PhaseItems) begin
        run_frame(n);
        sent += n;
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("encoder_window_trigger: match");
    end else begin
      $display("encoder_window_trigger: mismatch");
    end
    $finish;
  end

endmodule
